// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SNAGG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("snagg assertion failed");

`define SNAGG_NEVER(lbl, clk, rstn, cond) \
  `SNAGG_ASSERT(lbl, clk, rstn, !(cond))

`else

`define SNAGG_ASSERT(lbl, clk, rstn, prop)

`define SNAGG_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- hw/rtl/snagg_pkg.sv -----
package snagg_pkg;

  localparam int NUM_NODES    = 4096;
  localparam int ADDR_BITS    = $clog2(NUM_NODES);
  localparam int VALUE_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int NODE_BITS    = 12;
  localparam int LABEL_BITS   = 13;
  localparam int OP_BITS      = 2;
  localparam int OUTCOME_BITS = 3;

  // quotient magnitude that fits below the saturation limit
  localparam int QUOT_BITS = VALUE_BITS - 1;
  // integer bits of the quotient, used to seed the remainder
  localparam int PRE_SHIFT = QUOT_BITS - FRAC_BITS;
  localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

  typedef logic signed [VALUE_BITS-1:0] weight_t;
  typedef logic signed [LABEL_BITS-1:0] label_t;

  localparam label_t  NO_LABEL = '1;
  localparam weight_t SAT_POS  = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam weight_t SAT_NEG  = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD  = 2'd0,
    OP_ENTRY = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [OUTCOME_BITS-1:0] {
    OUT_AGGREGATED = 3'd0,
    OUT_JOINED     = 3'd1,
    OUT_STRONGEST  = 3'd2,
    OUT_ALONE      = 3'd3,
    OUT_READ       = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ_WAIT,
    ST_COL_WAIT,
    ST_DIV,
    ST_ROW_WAIT,
    ST_JOIN_WAIT,
    ST_EMIT
  } ctl_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_FIN
  } div_state_e;

  typedef struct packed {
    logic    start;
    weight_t value;
    weight_t diag_row;
    weight_t diag_col;
  } div_req_t;

  typedef struct packed {
    logic    done;
    weight_t weight;
  } div_rsp_t;

  function automatic logic [VALUE_BITS-1:0] magnitude(weight_t v);
    logic [VALUE_BITS-1:0] m;
    m = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

endpackage

// ----- hw/rtl/snagg_req_if.sv -----
interface snagg_req_if;

  logic                                     valid;
  logic                                     ready;
  logic [snagg_pkg::OP_BITS-1:0]            op;
  logic [snagg_pkg::NODE_BITS-1:0]          node_index;
  logic [snagg_pkg::NODE_BITS-1:0]          neighbor_col;
  logic signed [snagg_pkg::VALUE_BITS-1:0]  entry_value;
  logic signed [snagg_pkg::VALUE_BITS-1:0]  diag_row;
  logic signed [snagg_pkg::VALUE_BITS-1:0]  diag_col;
  logic                                     has_entry;
  logic                                     last_in_row;
  logic signed [snagg_pkg::LABEL_BITS-1:0]  load_label;

  modport source (
    output valid, op, node_index, neighbor_col, entry_value, diag_row, diag_col,
           has_entry, last_in_row, load_label,
    input  ready
  );

  modport sink (
    input  valid, op, node_index, neighbor_col, entry_value, diag_row, diag_col,
           has_entry, last_in_row, load_label,
    output ready
  );

endinterface

// ----- hw/rtl/snagg_rsp_if.sv -----
interface snagg_rsp_if;

  logic                                     valid;
  logic                                     ready;
  logic [snagg_pkg::NODE_BITS-1:0]          row_index;
  logic [snagg_pkg::OUTCOME_BITS-1:0]       outcome;
  logic signed [snagg_pkg::LABEL_BITS-1:0]  result_value;

  modport source (
    output valid, row_index, outcome, result_value,
    input  ready
  );

  modport sink (
    input  valid, row_index, outcome, result_value,
    output ready
  );

endinterface

// ----- hw/rtl/snagg_ram.sv -----
module snagg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/snagg_div.sv -----
module snagg_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  snagg_pkg::div_req_t  req_i,
  output snagg_pkg::div_rsp_t  rsp_o
);

  localparam int VB = snagg_pkg::VALUE_BITS;
  localparam int QB = snagg_pkg::QUOT_BITS;
  localparam int SH = snagg_pkg::PRE_SHIFT;
  localparam int FB = snagg_pkg::FRAC_BITS;

  snagg_pkg::div_state_e state_q, state_d;

  logic [VB-1:0]                    num_q, num_d;
  logic [VB-1:0]                    den_q, den_d;
  logic                             neg_q, neg_d;
  logic [VB-1:0]                    rem_q, rem_d;
  logic [QB-1:0]                    low_q, low_d;
  logic [QB-1:0]                    quot_q, quot_d;
  logic [snagg_pkg::CNT_BITS-1:0]   cnt_q, cnt_d;
  snagg_pkg::weight_t               weight_q, weight_d;
  logic                             done_q, done_d;

  logic [VB-1:0] mag_row;
  logic [VB-1:0] mag_col;
  logic [VB:0]   trial;
  logic          overflow;

  assign mag_row = snagg_pkg::magnitude(req_i.diag_row);
  assign mag_col = snagg_pkg::magnitude(req_i.diag_col);

  // quotient reaches 2^(VB-1) exactly when num >= den * 2^SH
  assign overflow = ((VB+SH)'(num_q)) >= {den_q, {SH{1'b0}}};
  assign trial    = {rem_q, low_q[QB-1]};

  always_comb begin
    state_d  = state_q;
    num_d    = num_q;
    den_d    = den_q;
    neg_d    = neg_q;
    rem_d    = rem_q;
    low_d    = low_q;
    quot_d   = quot_q;
    cnt_d    = cnt_q;
    weight_d = weight_q;
    done_d   = 1'b0;

    unique case (state_q)
      snagg_pkg::DV_IDLE: begin
        if (req_i.start) begin
          num_d   = snagg_pkg::magnitude(req_i.value);
          den_d   = (mag_row > mag_col) ? mag_row : mag_col;
          neg_d   = req_i.value[VB-1];
          state_d = snagg_pkg::DV_CHECK;
        end
      end
      snagg_pkg::DV_CHECK: begin
        if (num_q == '0) begin
          weight_d = '0;
          done_d   = 1'b1;
          state_d  = snagg_pkg::DV_IDLE;
        end else if (den_q == '0 || overflow) begin
          weight_d = neg_q ? snagg_pkg::SAT_NEG : snagg_pkg::SAT_POS;
          done_d   = 1'b1;
          state_d  = snagg_pkg::DV_IDLE;
        end else begin
          rem_d   = VB'(num_q >> SH);
          low_d   = {num_q[SH-1:0], {FB{1'b0}}};
          quot_d  = '0;
          cnt_d   = '0;
          state_d = snagg_pkg::DV_RUN;
        end
      end
      snagg_pkg::DV_RUN: begin
        // one restoring step per cycle
        if (trial >= {1'b0, den_q}) begin
          rem_d  = VB'(trial - {1'b0, den_q});
          quot_d = {quot_q[QB-2:0], 1'b1};
        end else begin
          rem_d  = trial[VB-1:0];
          quot_d = {quot_q[QB-2:0], 1'b0};
        end
        low_d = {low_q[QB-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == snagg_pkg::CNT_BITS'(QB - 1)) begin
          state_d = snagg_pkg::DV_FIN;
        end
      end
      snagg_pkg::DV_FIN: begin
        weight_d = neg_q ? (~{1'b0, quot_q} + 1'b1) : {1'b0, quot_q};
        done_d   = 1'b1;
        state_d  = snagg_pkg::DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snagg_pkg::DV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    den_q    <= den_d;
    neg_q    <= neg_d;
    rem_q    <= rem_d;
    low_q    <= low_d;
    quot_q   <= quot_d;
    weight_q <= weight_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.weight = weight_q;

endmodule

// ----- hw/rtl/strongest_neighbor_aggregation.sv -----
// Strongest-neighbor search for pairwise aggregation.
// req_i takes one request at a time: op load writes a node label, op read
// returns it, op entry streams one sparse-matrix entry (or an empty-row
// marker). Each row produces one result on rsp_o at its end: already
// aggregated, joined a neighbor's aggregate (label store updated), strongest
// unaggregated neighbor, or no neighbor. Read requests produce a read result.
// A load is written at dispatch; a read goes through dispatch, read wait and
// emit into the output register; a mid-row self-loop ends at dispatch. An entry
// that needs a full division reads the column label while the radix-2 divider
// checks for overflow, then computes 31 quotient bits, fixes the sign and hands
// over; a zero value, zero diagonals or an overflowing quotient finish at the
// check. A row end adds a row wait, and a join wait when the row joins an
// aggregate, for label store reads through its single read port. ready is high
// only while the sequencer is idle, so a new request is taken only once the
// last one is through. The result sits in an output register: a stalled
// receiver does not block new requests until the next result has to be
// handed over. Reset clears the sequencer, the trackers and the output
// valid; the label store is not cleared and must be loaded before use.
`include "assert_macros.svh"

module strongest_neighbor_aggregation (
  input  logic               clk_i,
  input  logic               rst_ni,
  snagg_req_if.sink          req_i,
  snagg_rsp_if.source        rsp_o
);

  localparam int AB = snagg_pkg::ADDR_BITS;
  localparam int LB = snagg_pkg::LABEL_BITS;

  snagg_pkg::ctl_state_e state_q, state_d;

  // captured request
  logic [snagg_pkg::OP_BITS-1:0]    op_q;
  logic [snagg_pkg::NODE_BITS-1:0]  node_q;
  logic [snagg_pkg::NODE_BITS-1:0]  col_q;
  snagg_pkg::weight_t               value_q;
  snagg_pkg::weight_t               diag_row_q;
  snagg_pkg::weight_t               diag_col_q;
  logic                             has_q;
  logic                             last_q;
  snagg_pkg::label_t                load_label_q;

  snagg_pkg::label_t   col_label_q, col_label_d;
  snagg_pkg::weight_t  unagg_w_q, unagg_w_d;
  snagg_pkg::label_t   unagg_col_q, unagg_col_d;
  snagg_pkg::weight_t  agg_w_q, agg_w_d;
  snagg_pkg::label_t   agg_col_q, agg_col_d;

  logic [snagg_pkg::OUTCOME_BITS-1:0] res_outcome_q, res_outcome_d;
  snagg_pkg::label_t                  res_value_q, res_value_d;

  logic                               out_valid_q;
  logic [snagg_pkg::NODE_BITS-1:0]    out_row_q;
  logic [snagg_pkg::OUTCOME_BITS-1:0] out_outcome_q;
  snagg_pkg::label_t                  out_value_q;
  logic                               out_load;

  logic          accept;
  logic          ram_we;
  logic [AB-1:0] ram_waddr;
  logic [LB-1:0] ram_wdata;
  logic          ram_re;
  logic [AB-1:0] ram_raddr;
  logic [LB-1:0] ram_rdata;
  snagg_pkg::label_t ram_label;

  snagg_pkg::div_req_t div_req;
  snagg_pkg::div_rsp_t div_rsp;

  snagg_pkg::label_t col_ext;
  logic              unagg_beats;
  logic              agg_beats;

  logic              in_div;
  logic              row_emit;
  logic              trackers_clear;
  logic              emit_stalled;

  assign accept    = req_i.valid && req_i.ready;
  assign ram_label = signed'(ram_rdata);
  assign col_ext   = signed'({1'b0, col_q});

  // ties go to the larger column
  assign unagg_beats = (div_rsp.weight > unagg_w_q) ||
                       (div_rsp.weight == unagg_w_q && col_ext > unagg_col_q);
  assign agg_beats   = (div_rsp.weight > agg_w_q) ||
                       (div_rsp.weight == agg_w_q && col_ext > agg_col_q);

  always_comb begin
    state_d          = state_q;
    req_i.ready      = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = node_q[AB-1:0];
    ram_wdata        = load_label_q;
    ram_re           = 1'b0;
    ram_raddr        = node_q[AB-1:0];
    div_req.start    = 1'b0;
    div_req.value    = value_q;
    div_req.diag_row = diag_row_q;
    div_req.diag_col = diag_col_q;
    col_label_d      = col_label_q;
    unagg_w_d        = unagg_w_q;
    unagg_col_d      = unagg_col_q;
    agg_w_d          = agg_w_q;
    agg_col_d        = agg_col_q;
    res_outcome_d    = res_outcome_q;
    res_value_d      = res_value_q;
    out_load         = 1'b0;

    unique case (state_q)
      snagg_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = snagg_pkg::ST_DISPATCH;
        end
      end
      snagg_pkg::ST_DISPATCH: begin
        unique case (op_q)
          snagg_pkg::OP_LOAD: begin
            ram_we  = 1'b1;
            state_d = snagg_pkg::ST_IDLE;
          end
          snagg_pkg::OP_READ: begin
            ram_re  = 1'b1;
            state_d = snagg_pkg::ST_READ_WAIT;
          end
          snagg_pkg::OP_ENTRY: begin
            if (has_q && col_q != node_q) begin
              ram_re        = 1'b1;
              ram_raddr     = col_q[AB-1:0];
              div_req.start = 1'b1;
              state_d       = snagg_pkg::ST_COL_WAIT;
            end else if (!has_q || last_q) begin
              ram_re  = 1'b1;
              state_d = snagg_pkg::ST_ROW_WAIT;
            end else begin
              // self-loop in the middle of a row
              state_d = snagg_pkg::ST_IDLE;
            end
          end
          default: begin
            state_d = snagg_pkg::ST_IDLE;
          end
        endcase
      end
      snagg_pkg::ST_READ_WAIT: begin
        res_outcome_d = snagg_pkg::OUT_READ;
        res_value_d   = ram_label;
        state_d       = snagg_pkg::ST_EMIT;
      end
      snagg_pkg::ST_COL_WAIT: begin
        col_label_d = ram_label;
        state_d     = snagg_pkg::ST_DIV;
      end
      snagg_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (col_label_q == snagg_pkg::NO_LABEL) begin
            if (unagg_beats) begin
              unagg_w_d   = div_rsp.weight;
              unagg_col_d = col_ext;
            end
          end else if (agg_beats) begin
            agg_w_d   = div_rsp.weight;
            agg_col_d = col_ext;
          end
          if (last_q) begin
            ram_re  = 1'b1;
            state_d = snagg_pkg::ST_ROW_WAIT;
          end else begin
            state_d = snagg_pkg::ST_IDLE;
          end
        end
      end
      snagg_pkg::ST_ROW_WAIT: begin
        if (ram_label != snagg_pkg::NO_LABEL) begin
          res_outcome_d = snagg_pkg::OUT_AGGREGATED;
          res_value_d   = ram_label;
          state_d       = snagg_pkg::ST_EMIT;
        end else if (unagg_col_q == snagg_pkg::NO_LABEL &&
                     agg_col_q != snagg_pkg::NO_LABEL) begin
          ram_re    = 1'b1;
          ram_raddr = agg_col_q[AB-1:0];
          state_d   = snagg_pkg::ST_JOIN_WAIT;
        end else if (unagg_col_q != snagg_pkg::NO_LABEL) begin
          res_outcome_d = snagg_pkg::OUT_STRONGEST;
          res_value_d   = unagg_col_q;
          state_d       = snagg_pkg::ST_EMIT;
        end else begin
          res_outcome_d = snagg_pkg::OUT_ALONE;
          res_value_d   = signed'({1'b0, node_q});
          state_d       = snagg_pkg::ST_EMIT;
        end
        if (state_d == snagg_pkg::ST_EMIT) begin
          unagg_w_d   = '0;
          unagg_col_d = snagg_pkg::NO_LABEL;
          agg_w_d     = '0;
          agg_col_d   = snagg_pkg::NO_LABEL;
        end
      end
      snagg_pkg::ST_JOIN_WAIT: begin
        ram_we        = 1'b1;
        ram_wdata     = ram_rdata;
        res_outcome_d = snagg_pkg::OUT_JOINED;
        res_value_d   = ram_label;
        unagg_w_d     = '0;
        unagg_col_d   = snagg_pkg::NO_LABEL;
        agg_w_d       = '0;
        agg_col_d     = snagg_pkg::NO_LABEL;
        state_d       = snagg_pkg::ST_EMIT;
      end
      snagg_pkg::ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = snagg_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= snagg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      unagg_w_q   <= '0;
      unagg_col_q <= snagg_pkg::NO_LABEL;
      agg_w_q     <= '0;
      agg_col_q   <= snagg_pkg::NO_LABEL;
    end else begin
      state_q     <= state_d;
      unagg_w_q   <= unagg_w_d;
      unagg_col_q <= unagg_col_d;
      agg_w_q     <= agg_w_d;
      agg_col_q   <= agg_col_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= req_i.op;
      node_q       <= req_i.node_index;
      col_q        <= req_i.neighbor_col;
      value_q      <= req_i.entry_value;
      diag_row_q   <= req_i.diag_row;
      diag_col_q   <= req_i.diag_col;
      has_q        <= req_i.has_entry;
      last_q       <= req_i.last_in_row;
      load_label_q <= req_i.load_label;
    end
    col_label_q   <= col_label_d;
    res_outcome_q <= res_outcome_d;
    res_value_q   <= res_value_d;
    if (out_load) begin
      out_row_q     <= node_q;
      out_outcome_q <= res_outcome_q;
      out_value_q   <= res_value_q;
    end
  end

  snagg_ram #(
    .WIDTH (LB),
    .DEPTH (snagg_pkg::NUM_NODES)
  ) u_label_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  snagg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.row_index    = out_row_q;
  assign rsp_o.outcome      = out_outcome_q;
  assign rsp_o.result_value = out_value_q;

  assign in_div         = (state_q == snagg_pkg::ST_DIV);
  assign row_emit       = (state_q == snagg_pkg::ST_EMIT) &&
                          (res_outcome_q != snagg_pkg::OUT_READ);
  assign trackers_clear = (unagg_col_q == snagg_pkg::NO_LABEL) &&
                          (agg_col_q == snagg_pkg::NO_LABEL);
  assign emit_stalled   = (state_q == snagg_pkg::ST_EMIT) && out_valid_q && !rsp_o.ready;

  // the divider only finishes while the sequencer waits for it
  `SNAGG_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_rsp.done |-> in_div)

  // every row-end result leaves both trackers cleared
  `SNAGG_ASSERT(a_trackers_clear, clk_i, rst_ni, row_emit |-> trackers_clear)

  // a pending result waits while the output register is still held
  `SNAGG_ASSERT(a_emit_holds, clk_i, rst_ni, emit_stalled |=> (state_q == snagg_pkg::ST_EMIT))

  // the label store is never written and read in the same cycle
  `SNAGG_NEVER(a_ram_rw_overlap, clk_i, rst_ni, ram_we && ram_re)

endmodule
